@@ hw/rtl/tclc_pkg.sv @@
package tclc_pkg;

   // field widths
   localparam int COUNT_W  = 16;
   localparam int LUX_W    = 20;
   localparam int REGION_W = 3;
   localparam int REQ_W    = 2 * COUNT_W;
   localparam int RSP_W    = 24;

   // power table entries are x^1.4 in Q16
   localparam int POW_W    = 16;
   localparam int POW_FRAC = 16;

   // formula coefficients, Q24
   localparam int COEF_W = 20;
   localparam logic [COEF_W-1:0] C0315 =
      COEF_W'((64'd315 * 64'd16777216 + 64'd5000) / 64'd10000);
   localparam logic [COEF_W-1:0] C0593 =
      COEF_W'((64'd593 * 64'd16777216 + 64'd5000) / 64'd10000);
   localparam logic [COEF_W-1:0] C0229 =
      COEF_W'((64'd229 * 64'd16777216 + 64'd5000) / 64'd10000);
   localparam logic [COEF_W-1:0] C0291 =
      COEF_W'((64'd291 * 64'd16777216 + 64'd5000) / 64'd10000);
   localparam logic [COEF_W-1:0] C0157 =
      COEF_W'((64'd157 * 64'd16777216 + 64'd5000) / 64'd10000);
   localparam logic [COEF_W-1:0] C0180 =
      COEF_W'((64'd180 * 64'd16777216 + 64'd5000) / 64'd10000);
   localparam logic [COEF_W-1:0] C0338 =
      COEF_W'((64'd338 * 64'd16777216 + 64'd50000) / 64'd100000);
   localparam logic [COEF_W-1:0] C0260 =
      COEF_W'((64'd260 * 64'd16777216 + 64'd50000) / 64'd100000);

   localparam logic [LUX_W-1:0] LUX_MAX = '1;

   // ratio region codes
   localparam logic [REGION_W-1:0] REGION_SEG0 = 3'd0;
   localparam logic [REGION_W-1:0] REGION_SEG1 = 3'd1;
   localparam logic [REGION_W-1:0] REGION_SEG2 = 3'd2;
   localparam logic [REGION_W-1:0] REGION_SEG3 = 3'd3;
   localparam logic [REGION_W-1:0] REGION_HIGH = 3'd4;
   localparam logic [REGION_W-1:0] REGION_ZERO = 3'd5;

   // parameter defaults
   localparam int DEF_RATIO_FRAC_BITS   = 14;
   localparam int DEF_POW_TABLE_ENTRIES = 64;
   localparam int DEF_LUX_FRAC_BITS     = 8;

   // largest k with k^5 <= a * 2^48, evaluated at elaboration for the table
   function automatic logic [15:0] fifth_root(input logic [63:0] a);
      logic [95:0] tgt;
      logic [95:0] pw;
      logic [16:0] lo;
      logic [16:0] hi;
      logic [16:0] m;
      tgt = 96'(a) << 48;
      lo  = '0;
      hi  = 17'd65535;
      for (int it = 0; it < 17; it++) begin
         if (lo < hi) begin
            m  = (lo + hi + 17'd1) >> 1;
            pw = 96'(m) * 96'(m) * 96'(m) * 96'(m) * 96'(m);
            if (pw <= tgt) begin
               lo = m;
            end else begin
               hi = m - 17'd1;
            end
         end
      end
      return lo[15:0];
   endfunction

endpackage

@@ hw/rtl/two_channel_lux_calc.sv @@
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata[15:0] broad_count, [31:16] ir_count
// rsp      out        rsp_tvalid/rsp_tready  tdata[19:0] lux_q8; tuser[2:0] ratio_region
//
// One transfer per cycle sustained while rsp_tready stays high.
// The restoring divider produces one quotient bit per register stage.
// Reset is synchronous and active high; it clears the valid bits only.
// A result that waits on rsp_tready holds the whole pipeline in place; req_tready
// drops while it waits, so nothing is lost or repeated.
module two_channel_lux_calc
   import tclc_pkg::*;
#(
   parameter int RATIO_FRAC_BITS   = DEF_RATIO_FRAC_BITS,
   parameter int POW_TABLE_ENTRIES = DEF_POW_TABLE_ENTRIES,
   parameter int LUX_FRAC_BITS     = DEF_LUX_FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // [15:0] broad_count, [31:16] ir_count
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // [19:0] lux_q8, [23:20] zero
   output logic [REGION_W-1:0] rsp_tuser // [2:0] ratio_region
);

   localparam int RFB = RATIO_FRAC_BITS;
   localparam int N   = POW_TABLE_ENTRIES;
   localparam int RW  = RFB + 2;              // ratio width, Q2.RFB
   localparam int FW  = RW + 1;               // fraction before correction
   localparam int PB  = $clog2(N);            // table index width
   localparam int NB  = RW + PB;              // scaled ratio n = r*(N-1)
   localparam int M1W = PB + 3;
   localparam int P1W = NB + M1W;
   localparam int DFW = POW_W + RW;           // table delta times fraction
   localparam int M2W = POW_W + 3;
   localparam int P2W = DFW + M2W;
   localparam int LINW = COUNT_W + COEF_W;    // linear terms, Q24
   localparam int BYW  = COUNT_W + POW_W;
   localparam int S0W  = BYW + COEF_W;        // segment zero terms, Q40
   localparam int QPW  = RW + COUNT_W + 1;
   localparam int SH0  = 40 - LUX_FRAC_BITS;
   localparam int SHL  = 24 - LUX_FRAC_BITS;

   // ratio thresholds
   localparam logic [RW-1:0] T52  = RW'(((52 << RFB) + 50) / 100);
   localparam logic [RW-1:0] T65  = RW'(((65 << RFB) + 50) / 100);
   localparam logic [RW-1:0] T80  = RW'(((80 << RFB) + 50) / 100);
   localparam logic [RW-1:0] T130 = RW'(((130 << RFB) + 50) / 100);

   localparam logic [PB-1:0] NM1 = PB'(N - 1);

   // reciprocals of T52; the estimate is low by at most one
   localparam logic [M1W-1:0] M1 = M1W'((64'd1 << NB) / 64'(T52));
   localparam logic [M2W-1:0] M2 = M2W'((64'd1 << DFW) / 64'(T52));

   // stage map: 0 capture, 1..RW divide, then the fixed stages below
   localparam int ST_A = RW + 1;   // ratio, region, scaled ratio
   localparam int ST_B = RW + 2;   // reciprocal product, linear terms
   localparam int ST_C = RW + 3;   // index and fraction estimate
   localparam int ST_D = RW + 4;   // index correction
   localparam int ST_E = RW + 5;   // table read
   localparam int ST_F = RW + 6;   // delta times fraction
   localparam int ST_G = RW + 7;   // reciprocal product
   localparam int ST_H = RW + 8;   // interpolation estimate
   localparam int ST_I = RW + 9;   // interpolated power
   localparam int ST_J = RW + 10;  // broad times power
   localparam int ST_K = RW + 11;  // times coefficient
   localparam int ST_L = RW + 12;  // lux select and saturate
   localparam int NST  = RW + 13;

   typedef struct packed {
      logic [COUNT_W-1:0]  broad;
      logic [COUNT_W-1:0]  ir;
      logic                bzero;
      logic                sat;
      logic [COUNT_W-1:0]  rem;
      logic [RW-1:0]       q;
      logic [REGION_W-1:0] region;
      logic [NB-1:0]       n;
      logic [P1W-1:0]      prod1;
      logic [LINW-1:0]     alin;
      logic [LINW-1:0]     slin;
      logic [LINW-1:0]     p315;
      logic [PB-1:0]       bidx;
      logic [FW-1:0]       fr;
      logic [POW_W-1:0]    eb;
      logic [POW_W-1:0]    d;
      logic [DFW-1:0]      df;
      logic [P2W-1:0]      prod2;
      logic [POW_W-1:0]    q2;
      logic [FW-1:0]       rem2;
      logic [POW_W-1:0]    y;
      logic [BYW-1:0]      by;
      logic [S0W-1:0]      s0;
      logic [LUX_W-1:0]    lux;
   } lane_type;

   // x^1.4 table, built at elaboration
   logic [POW_W-1:0] pow_tab [N];

   for (genvar gi = 0; gi < N; gi++) begin : g_tab
      localparam logic [63:0] XV = (64'(gi) * 64'd6815744 + 64'd100 * 64'(N - 1))
                                   / (64'd200 * 64'(N - 1));
      localparam logic [15:0] KV = fifth_root(XV * XV);
      localparam logic [POW_W-1:0] EV = POW_W'((XV * 64'(KV)) >> POW_FRAC);
      assign pow_tab[gi] = EV;
   end

   lane_type         pipe_ff [NST];
   lane_type         pipe_in [NST];
   logic [NST-1:0]   valid_ff;
   logic [NST-1:0]   valid_in;
   logic             advance;

   // the pipeline moves as one; it holds only while a result waits
   assign advance    = !valid_ff[ST_L] || rsp_tready;
   assign req_tready = advance;
   assign valid_in   = {valid_ff[NST-2:0], req_tvalid};

   always_comb begin
      lane_type             p;
      logic [COUNT_W:0]     sh;
      logic                 ge;
      logic                 nbit;
      logic [RW-1:0]        r;
      logic [RW-1:0]        rc;
      logic [COEF_W-1:0]    ca;
      logic [COEF_W-1:0]    cb;
      logic [PB-1:0]        idx1;
      logic [S0W-1:0]       a0;
      logic [S0W-1:0]       val;

      // capture: saturation is ir >= 4*broad; the divider starts from ir/4
      p       = '0;
      p.broad = req_tdata[COUNT_W-1:0];
      p.ir    = req_tdata[REQ_W-1:COUNT_W];
      p.bzero = (p.broad == '0);
      p.sat   = {2'b00, p.ir} >= {p.broad, 2'b00};
      p.rem   = {2'b00, p.ir[COUNT_W-1:2]};
      pipe_in[0] = p;

      // restoring divide, one quotient bit per stage; low numerator bits are
      // ir[1], ir[0] and then zeros
      for (int k = 1; k <= RW; k++) begin
         p = pipe_ff[k-1];
         if (k == 1) begin
            nbit = p.ir[1];
         end else if (k == 2) begin
            nbit = p.ir[0];
         end else begin
            nbit = 1'b0;
         end
         sh = {p.rem, nbit};
         ge = sh >= {1'b0, p.broad};
         if (ge) begin
            sh = sh - {1'b0, p.broad};
         end
         p.rem = sh[COUNT_W-1:0];
         p.q   = {p.q[RW-2:0], ge};
         pipe_in[k] = p;
      end

      // A: saturate the ratio and pick the region
      p  = pipe_ff[ST_A-1];
      r  = p.sat ? '1 : p.q;
      if (p.bzero) begin
         p.region = REGION_ZERO;
      end else if (r <= T52) begin
         p.region = REGION_SEG0;
      end else if (r > T130) begin
         p.region = REGION_HIGH;
      end else if (r <= T65) begin
         p.region = REGION_SEG1;
      end else if (r <= T80) begin
         p.region = REGION_SEG2;
      end else begin
         p.region = REGION_SEG3;
      end
      rc  = (r <= T52) ? r : T52;
      p.n = NB'(rc) * NB'(NM1);
      pipe_in[ST_A] = p;

      // B: reciprocal product for n / T52, linear segment terms
      p = pipe_ff[ST_B-1];
      case (p.region)
         REGION_SEG1: begin
            ca = C0229;
            cb = C0291;
         end
         REGION_SEG2: begin
            ca = C0157;
            cb = C0180;
         end
         default: begin
            ca = C0338;
            cb = C0260;
         end
      endcase
      p.prod1 = P1W'(p.n) * P1W'(M1);
      p.alin  = LINW'(ca) * LINW'(p.broad);
      p.slin  = LINW'(cb) * LINW'(p.ir);
      p.p315  = LINW'(C0315) * LINW'(p.broad);
      pipe_in[ST_B] = p;

      // C: index estimate and remainder
      p      = pipe_ff[ST_C-1];
      p.bidx = p.prod1[NB +: PB];
      p.fr   = FW'(p.n - NB'(p.bidx) * NB'(T52));
      pipe_in[ST_C] = p;

      // D: fix an estimate that came out one low
      p = pipe_ff[ST_D-1];
      if (p.fr >= FW'(T52)) begin
         p.bidx = p.bidx + PB'(1);
         p.fr   = p.fr - FW'(T52);
      end
      pipe_in[ST_D] = p;

      // E: read two neighbors; at the last entry the delta is zero
      p    = pipe_ff[ST_E-1];
      idx1 = (p.bidx == NM1) ? p.bidx : p.bidx + PB'(1);
      p.eb = pow_tab[p.bidx];
      p.d  = pow_tab[idx1] - pow_tab[p.bidx];
      pipe_in[ST_E] = p;

      // F
      p    = pipe_ff[ST_F-1];
      p.df = DFW'(p.d) * DFW'(p.fr[RW-1:0]);
      pipe_in[ST_F] = p;

      // G
      p       = pipe_ff[ST_G-1];
      p.prod2 = P2W'(p.df) * P2W'(M2);
      pipe_in[ST_G] = p;

      // H
      p      = pipe_ff[ST_H-1];
      p.q2   = p.prod2[DFW +: POW_W];
      p.rem2 = FW'(p.df - DFW'(p.q2) * DFW'(T52));
      pipe_in[ST_H] = p;

      // I
      p   = pipe_ff[ST_I-1];
      p.y = p.eb + p.q2 + POW_W'(p.rem2 >= FW'(T52));
      pipe_in[ST_I] = p;

      // J
      p    = pipe_ff[ST_J-1];
      p.by = BYW'(p.broad) * BYW'(p.y);
      pipe_in[ST_J] = p;

      // K
      p    = pipe_ff[ST_K-1];
      p.s0 = S0W'(p.by) * S0W'(C0593);
      pipe_in[ST_K] = p;

      // L: subtract, clamp at zero, scale and saturate
      p  = pipe_ff[ST_L-1];
      a0 = S0W'({p.p315, {POW_FRAC{1'b0}}});
      case (p.region)
         REGION_SEG0: begin
            val = (p.s0 >= a0) ? '0 : ((a0 - p.s0) >> SH0);
         end
         REGION_SEG1, REGION_SEG2, REGION_SEG3: begin
            val = (p.slin >= p.alin) ? '0 : S0W'((p.alin - p.slin) >> SHL);
         end
         default: begin
            val = '0;
         end
      endcase
      p.lux = (val > S0W'(LUX_MAX)) ? LUX_MAX : val[LUX_W-1:0];
      pipe_in[ST_L] = p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff <= pipe_in;
      end
   end

   assign rsp_tvalid = valid_ff[ST_L];
   assign rsp_tdata  = RSP_W'(pipe_ff[ST_L].lux);
   assign rsp_tuser  = pipe_ff[ST_L].region;

   // no light result outside the formula segments
   a_zero_region : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == REGION_HIGH || rsp_tuser == REGION_ZERO)
      |-> rsp_tdata[LUX_W-1:0] == '0)
      else $error("lux not zero outside formula segments");

   // divider output is the floor quotient when not saturated
   a_divide : assert property (@(posedge clock) disable iff (reset)
      valid_ff[RW] && !pipe_ff[RW].bzero && !pipe_ff[RW].sat
      |-> (QPW'(pipe_ff[RW].q) * QPW'(pipe_ff[RW].broad)
              <= (QPW'(pipe_ff[RW].ir) << RFB))
       && ((QPW'(pipe_ff[RW].q) + QPW'(1)) * QPW'(pipe_ff[RW].broad)
              > (QPW'(pipe_ff[RW].ir) << RFB)))
      else $error("ratio quotient out of range");

   // corrected index and fraction stay in range
   a_index : assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_D] |-> pipe_ff[ST_D].fr < FW'(T52) && pipe_ff[ST_D].bidx <= NM1)
      else $error("table index or fraction out of range");

   // interpolated value lies between the two neighbors
   a_interp : assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_I] |-> pipe_ff[ST_I].y >= pipe_ff[ST_I].eb
         && (POW_W + 1)'(pipe_ff[ST_I].y)
            <= (POW_W + 1)'(pipe_ff[ST_I].eb) + (POW_W + 1)'(pipe_ff[ST_I].d))
      else $error("interpolation outside table neighbors");

endmodule

@@ tb/two_channel_lux_calc_test.sv @@
`timescale 1ns / 1ps

module two_channel_lux_calc_test
   import tclc_pkg::*;
();

   // block configuration under test, kept at the package defaults
   localparam int RATIO_FB = DEF_RATIO_FRAC_BITS;
   localparam int POW_N    = DEF_POW_TABLE_ENTRIES;
   localparam int LUX_FB   = DEF_LUX_FRAC_BITS;

   // pipeline depth: the capture stage, one divider stage per quotient bit and the formula stages
   localparam int LATENCY     = RATIO_FB + 15;
   localparam int RANDOM_ITEMS = 1200;
   localparam int CYCLE_LIMIT  = 200000;

   // receiver hold-off window and stretches without idling
   localparam int HOLD_START      = 600;
   localparam int HOLD_CYCLES     = 200;
   localparam int RX_BUSY_START   = 1200;
   localparam int RX_BUSY_CYCLES  = 400;
   localparam int TX_BUSY_FIRST   = 700;
   localparam int TX_BUSY_LAST    = 950;

   // ratio thresholds, rounded to the ratio's fraction bits
   localparam logic [63:0] RATIO_SAT = (64'd1 << (RATIO_FB + 2)) - 64'd1;
   localparam logic [63:0] TH_052 = ((64'd52 << RATIO_FB) + 64'd50) / 64'd100;
   localparam logic [63:0] TH_065 = ((64'd65 << RATIO_FB) + 64'd50) / 64'd100;
   localparam logic [63:0] TH_080 = ((64'd80 << RATIO_FB) + 64'd50) / 64'd100;
   localparam logic [63:0] TH_130 = ((64'd130 << RATIO_FB) + 64'd50) / 64'd100;

   // formula weights in Q24
   localparam logic [63:0] K0315 = ((64'd315 << 24) + 64'd5000) / 64'd10000;
   localparam logic [63:0] K0593 = ((64'd593 << 24) + 64'd5000) / 64'd10000;
   localparam logic [63:0] K0229 = ((64'd229 << 24) + 64'd5000) / 64'd10000;
   localparam logic [63:0] K0291 = ((64'd291 << 24) + 64'd5000) / 64'd10000;
   localparam logic [63:0] K0157 = ((64'd157 << 24) + 64'd5000) / 64'd10000;
   localparam logic [63:0] K0180 = ((64'd180 << 24) + 64'd5000) / 64'd10000;
   localparam logic [63:0] K0338 = ((64'd338 << 24) + 64'd50000) / 64'd100000;
   localparam logic [63:0] K0260 = ((64'd260 << 24) + 64'd50000) / 64'd100000;

   typedef struct packed {
      logic [LUX_W-1:0]    lux;
      logic [REGION_W-1:0] region;
   } lux_reading_type;

   // Holds the lux readings still owed by the block, oldest first, and checks
   // each returned transfer against the front of the queue.
   class lux_scoreboard;
      logic [63:0]  pow_q16 [POW_N];
      lux_reading_type owed_q [$];
      int           mismatches;
      int           pairs_seen;
      int           readings_checked;
      int           region_hits [6];

      function new();
         logic [63:0] x;
         logic [63:0] k;
         mismatches = 0;
         pairs_seen = 0;
         readings_checked = 0;
         foreach (region_hits[j]) region_hits[j] = 0;
         // x^1.4 table in Q16 over 0..0.52, built as x * x^0.4
         for (int i = 0; i < POW_N; i++) begin
            x = (64'(i) * 64'd52 * 64'd65536 * 64'd2 + 64'd100 * 64'(POW_N - 1))
                / (64'd200 * 64'(POW_N - 1));
            k = 64'(root5_floor(x * x));
            pow_q16[i] = (x * k) >> 16;
         end
      endfunction

      // largest k below 2^16 with k^5 <= sq * 2^48
      function logic [15:0] root5_floor(logic [63:0] sq);
         logic [127:0] target;
         logic [127:0] p;
         logic [16:0]  lo;
         logic [16:0]  hi;
         logic [16:0]  m;
         target = {64'd0, sq} << 48;
         lo = '0;
         hi = 17'd65535;
         while (lo < hi) begin
            m = (lo + hi + 17'd1) >> 1;
            p = 128'(m) * 128'(m) * 128'(m) * 128'(m) * 128'(m);
            if (p <= target) begin
               lo = m;
            end else begin
               hi = m - 17'd1;
            end
         end
         return lo[15:0];
      endfunction

      function lux_reading_type compute_lux(logic [15:0] broad, logic [15:0] ir);
         logic [63:0]  r;
         logic [63:0]  n;
         logic [63:0]  b;
         logic [63:0]  f;
         logic [63:0]  y;
         logic [63:0]  a;
         logic [63:0]  s;
         logic [63:0]  ca;
         logic [63:0]  cb;
         logic [63:0]  lux;
         lux_reading_type res;
         lux = '0;
         if (broad == '0) begin
            res.lux    = '0;
            res.region = REGION_ZERO;
            return res;
         end
         r = ({48'd0, ir} << RATIO_FB) / 64'(broad);
         if (r > RATIO_SAT) r = RATIO_SAT;
         if (r <= TH_052) begin
            // interpolate the power table, then broad*(0.0315 - 0.0593*r^1.4)
            n = r * 64'(POW_N - 1);
            b = n / TH_052;
            f = n % TH_052;
            if (b >= 64'(POW_N - 1)) begin
               y = pow_q16[POW_N-1];
            end else begin
               y = pow_q16[b] + ((pow_q16[b+1] - pow_q16[b]) * f) / TH_052;
            end
            a = 64'(broad) * (K0315 << 16);
            s = 64'(broad) * K0593 * y;
            lux = (s >= a) ? 64'd0 : (a - s) >> (40 - LUX_FB);
            res.region = REGION_SEG0;
         end else if (r > TH_130) begin
            res.region = REGION_HIGH;
         end else begin
            if (r <= TH_065) begin
               ca = K0229;
               cb = K0291;
               res.region = REGION_SEG1;
            end else if (r <= TH_080) begin
               ca = K0157;
               cb = K0180;
               res.region = REGION_SEG2;
            end else begin
               ca = K0338;
               cb = K0260;
               res.region = REGION_SEG3;
            end
            a = ca * 64'(broad);
            s = cb * 64'(ir);
            lux = (s >= a) ? 64'd0 : (a - s) >> (24 - LUX_FB);
         end
         if (lux > 64'(LUX_MAX)) lux = 64'(LUX_MAX);
         res.lux = lux[LUX_W-1:0];
         return res;
      endfunction

      function void note_pair(logic [15:0] broad, logic [15:0] ir);
         lux_reading_type exp_r;
         exp_r = compute_lux(broad, ir);
         owed_q.push_back(exp_r);
         pairs_seen++;
         region_hits[exp_r.region]++;
      endfunction

      function void check_result(logic [RSP_W-1:0] data, logic [REGION_W-1:0] region);
         lux_reading_type exp_r;
         if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected reading: lux %0d region %0d", data, region);
            return;
         end
         exp_r = owed_q.pop_front();
         readings_checked++;
         // the pad bits above lux_q8 must read as zero
         if (data != RSP_W'(exp_r.lux) || region != exp_r.region) begin
            mismatches++;
            if (mismatches <= 10)
               $display("reading %0d: expected lux %0d region %0d, got tdata %0h region %0d",
                        readings_checked, exp_r.lux, exp_r.region, data, region);
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;    // [15:0] broad_count, [31:16] ir_count
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;    // [19:0] lux_q8, [23:20] zero
   logic [REGION_W-1:0] rsp_tuser; // [2:0] ratio_region

   lux_scoreboard sb = new();
   int unsigned   cycle_count;

   two_channel_lux_calc #(
      .RATIO_FRAC_BITS   (RATIO_FB),
      .POW_TABLE_ENTRIES (POW_N),
      .LUX_FRAC_BITS     (LUX_FB)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog: a hung pipeline ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d readings still owed",
                  cycle_count, sb.pending());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // sample both channels at the rising edge; a transfer happens where
   // tvalid and tready are both high
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_pair(req_tdata[15:0], req_tdata[31:16]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Receiver: random back-pressure, one long hold-off so the pipeline fills
   // and stalls the request side, and one long stretch always ready.
   initial begin : receiver
      int unsigned rx_cycle;
      rx_cycle = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
            rsp_tready <= 1'b0;
         end else if (rx_cycle >= RX_BUSY_START &&
                      rx_cycle < RX_BUSY_START + RX_BUSY_CYCLES) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 20);
         end
         rx_cycle++;
         @(negedge clock);
      end
   end

   // Called at a falling edge; offer one pair, wait for the transfer and
   // return at the next falling edge with tvalid still high.
   task automatic drive_pair(input logic [15:0] broad, input logic [15:0] ir,
                             input bit may_idle);
      while (may_idle && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ir, broad};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly pairs aimed at one ratio band or band edge by picking a target ratio; the
   // rest are raw random counts, zero broadband and tiny counts.
   task automatic pick_pair(output logic [15:0] broad, output logic [15:0] ir);
      int unsigned kind;
      logic [63:0] rt;
      logic [63:0] prod;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         broad = 16'($urandom);
         ir    = 16'($urandom);
      end else if (kind < 12) begin
         broad = '0;
         ir    = 16'($urandom);
      end else if (kind < 18) begin
         broad = 16'($urandom_range(1, 15));
         ir    = 16'($urandom_range(0, 40));
      end else begin
         broad = 16'($urandom_range(1, 65535));
         case ($urandom_range(0, 5))
            0: rt = 64'($urandom_range(0, 32'(TH_052)));
            1: rt = 64'($urandom_range(32'(TH_052) + 1, 32'(TH_065)));
            2: rt = 64'($urandom_range(32'(TH_065) + 1, 32'(TH_080)));
            3: rt = 64'($urandom_range(32'(TH_080) + 1, 32'(TH_130)));
            4: rt = 64'($urandom_range(32'(TH_130) + 1, 32'(RATIO_SAT)));
            default: begin
               // land on or just past a band edge
               case ($urandom_range(0, 3))
                  0: rt = TH_052;
                  1: rt = TH_065;
                  2: rt = TH_080;
                  default: rt = TH_130;
               endcase
               rt = rt + 64'($urandom_range(0, 1));
            end
         endcase
         prod = (64'(broad) * rt) >> RATIO_FB;
         ir = (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
      end
   endtask

   initial begin : stimulus
      logic [31:0] corner_pairs [$];
      logic [15:0] broad;
      logic [15:0] ir;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      cycle_count = 0;

      // {ir, broad}; with broad = 16384 the ratio equals ir exactly
      corner_pairs = '{
         {16'h0000, 16'h0000},  // broadband zero, no IR
         {16'hFFFF, 16'h0000},  // broadband zero, full IR
         {16'h0000, 16'hFFFF},  // full scale, no IR
         {16'hFFFF, 16'hFFFF},  // equal counts
         {16'hFFFF, 16'h0001},  // ratio saturates
         {16'h0001, 16'h0001},
         {16'h0000, 16'h0001},
         {16'd8520, 16'd16384}, // ratio edges of each band
         {16'd8521, 16'd16384},
         {16'd10650, 16'd16384},
         {16'd10651, 16'd16384},
         {16'd13107, 16'd16384},
         {16'd13108, 16'd16384},
         {16'd21299, 16'd16384},
         {16'd21300, 16'd16384},
         {16'h5555, 16'hAAAA},
         {16'hAAAA, 16'h5555},
         {16'h7FFF, 16'hFFFF},
         {16'd52, 16'd100},
         {16'd130, 16'd100}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (corner_pairs[i])
         drive_pair(corner_pairs[i][15:0], corner_pairs[i][31:16], 1'b1);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick_pair(broad, ir);
         drive_pair(broad, ir, !(i >= TX_BUSY_FIRST && i < TX_BUSY_LAST));
      end
      req_tvalid <= 1'b0;

      // drain, then watch a while longer for stray readings
      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * LATENCY + 10) @(posedge clock);

      $display("Sent %0d count pairs, checked %0d lux readings, %0d mismatches",
               sb.pairs_seen, sb.readings_checked, sb.mismatches);
      $display("Bands hit: seg0 %0d seg1 %0d seg2 %0d seg3 %0d above 1.30 %0d zero %0d",
               sb.region_hits[0], sb.region_hits[1], sb.region_hits[2],
               sb.region_hits[3], sb.region_hits[4], sb.region_hits[5]);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ two_channel_lux_calc.f @@
hw/rtl/tclc_pkg.sv
hw/rtl/two_channel_lux_calc.sv
tb/two_channel_lux_calc_test.sv
